>>> rtl/ipra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipra_pkg
// Shared sizes, codes and controller/datapath interface types of the
// sorted IPv4 range allow table.
// ----------------------------------------------------------------------------
package ipra_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = 32;
  localparam int ENTRY_W     = 2 * ADDR_W;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] STAT_INSERTED  = 2'd0;
  localparam logic [1:0] STAT_WIDENED   = 2'd1;
  localparam logic [1:0] STAT_UNCHANGED = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic load;
    logic rd_mid;
    logic eval;
    logic mark_full;
    logic sh_init;
    logic sh_step;
    logic place;
    logic out_load;
  } ipra_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic search_open;
    logic hit;
    logic full;
    logic need_shift;
    logic shift_last;
  } ipra_sts_t;

endpackage

>>> rtl/ip_range_allow_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_range_allow_table
// Sorted IPv4 range allow table, 1024 entries, one item at a time. An insert
// takes the transaction and runs a binary search, a read and an evaluate step
// per probe (up to 10 probes at 1023 entries), then closes the search, primes
// the shift and moves each entry above the insert slot up one place when
// needed, places the entry and loads the result. A lookup takes the
// transaction, runs the binary search, closes it and loads the result. The
// entry memory has one registered read and one write per cycle. A new
// transaction is taken while the previous result waits in the output
// register. The entry memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module ip_range_allow_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_operation,
  input  logic [ipra_pkg::ADDR_W-1:0] in_range_start,
  input  logic [ipra_pkg::ADDR_W-1:0] in_range_end,
  input  logic [ipra_pkg::ADDR_W-1:0] in_query_address,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_allowed,
  output logic [1:0]                 out_insert_status
);
  import ipra_pkg::*;

  ipra_cmd_t cmd;
  ipra_sts_t sts;

  ipra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  ipra_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_operation      (in_operation),
    .in_range_start    (in_range_start),
    .in_range_end      (in_range_end),
    .in_query_address  (in_query_address),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_allowed       (out_allowed),
    .out_insert_status (out_insert_status)
  );

endmodule

>>> rtl/ipra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipra_ctrl
// Sequencer of the range table: binary search, shift-up for a new entry,
// and the output handshake.
// ----------------------------------------------------------------------------
module ipra_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output ipra_pkg::ipra_cmd_t cmd_o,
  input  ipra_pkg::ipra_sts_t sts_i
);
  import ipra_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_PROBE    = 7'b0000010,
    S_EVAL     = 7'b0000100,
    S_SH_PRIME = 7'b0001000,
    S_SHIFT    = 7'b0010000,
    S_PLACE    = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_o         = '0;
    in_ready      = 1'b0;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_PROBE;
        end
      end
      S_PROBE: begin
        priority if (sts_i.search_open) begin
          cmd_o.rd_mid = 1'b1;
          state_nxt    = S_EVAL;
        end else if (sts_i.is_lookup) begin
          state_nxt = S_DONE;
        end else if (sts_i.full) begin
          cmd_o.mark_full = 1'b1;
          state_nxt       = S_DONE;
        end else if (sts_i.need_shift) begin
          state_nxt = S_SH_PRIME;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_nxt  = sts_i.hit ? S_DONE : S_PROBE;
      end
      S_SH_PRIME: begin
        cmd_o.sh_init = 1'b1;
        state_nxt     = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.sh_step = 1'b1;
        if (sts_i.shift_last) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_PROBE))
    else $error("accepted transaction did not start a search");

  a_done_waits_for_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_free) |=> (state_r == S_DONE && out_valid_r))
    else $error("result left while the output slot was busy");

endmodule

>>> rtl/ipra_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipra_dp
// Datapath of the range table: entry memory, search bounds, shift pointer,
// entry count and result registers.
// ----------------------------------------------------------------------------
module ipra_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_operation,
  input  logic [ipra_pkg::ADDR_W-1:0] in_range_start,
  input  logic [ipra_pkg::ADDR_W-1:0] in_range_end,
  input  logic [ipra_pkg::ADDR_W-1:0] in_query_address,
  input  ipra_pkg::ipra_cmd_t         cmd_i,
  output ipra_pkg::ipra_sts_t         sts_o,
  output logic                       out_allowed,
  output logic [1:0]                 out_insert_status
);
  import ipra_pkg::*;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  logic              op_r;
  logic [ADDR_W-1:0] s_r, e_r, a_r;
  logic [CNT_W-1:0]  lo_r, hi_r, wptr_r, count_r;
  logic              res_allowed_r;
  logic [1:0]        res_status_r;
  logic              out_allowed_r;
  logic [1:0]        out_status_r;

  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  count_m1, wptr_m2;
  logic [ADDR_W-1:0] rd_start, rd_end;
  logic              is_lookup, look_hit, ins_hit, hit, go_left, widen;
  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [ENTRY_W-1:0] wdata;

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r} - (CNT_W + 1)'(1);
  assign mid      = mid_sum[CNT_W:1];
  assign count_m1 = count_r - CNT_W'(1);
  assign wptr_m2  = wptr_r - CNT_W'(2);

  assign rd_start  = rdata_r[ENTRY_W-1:ADDR_W];
  assign rd_end    = rdata_r[ADDR_W-1:0];
  assign is_lookup = (op_r == OP_LOOKUP);
  assign look_hit  = (rd_start <= a_r) && (rd_end >= a_r);
  assign ins_hit   = (rd_start == s_r);
  assign hit       = is_lookup ? look_hit : ins_hit;
  assign go_left   = is_lookup ? (rd_start > a_r) : (rd_start >= s_r);
  assign widen     = e_r > rd_end;

  assign sts_o.is_lookup   = is_lookup;
  assign sts_o.search_open = lo_r < hi_r;
  assign sts_o.hit         = hit;
  assign sts_o.full        = count_r >= CNT_W'(TABLE_DEPTH);
  assign sts_o.need_shift  = count_r > lo_r;
  assign sts_o.shift_last  = wptr_r == (lo_r + CNT_W'(1));

  always_comb begin
    we    = 1'b0;
    waddr = lo_r[IDX_W-1:0];
    wdata = {s_r, e_r};
    raddr = mid[IDX_W-1:0];
    if (cmd_i.eval && !is_lookup && ins_hit && widen) begin
      we    = 1'b1;
      waddr = mid[IDX_W-1:0];
    end
    if (cmd_i.sh_init) begin
      raddr = count_m1[IDX_W-1:0];
    end
    if (cmd_i.sh_step) begin
      we    = 1'b1;
      waddr = wptr_r[IDX_W-1:0];
      wdata = rdata_r;
      raddr = wptr_m2[IDX_W-1:0];
    end
    if (cmd_i.place) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_mid || cmd_i.sh_init || cmd_i.sh_step) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd_i.place) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op_r <= in_operation;
      s_r  <= in_range_start;
      e_r  <= in_range_end;
      a_r  <= in_query_address;
      lo_r <= '0;
      hi_r <= count_r;
    end else if (cmd_i.eval && !hit) begin
      if (go_left) begin
        hi_r <= mid;
      end else begin
        lo_r <= mid + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.sh_init) begin
      wptr_r <= count_r;
    end else if (cmd_i.sh_step) begin
      wptr_r <= wptr_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      res_allowed_r <= 1'b0;
      res_status_r  <= STAT_INSERTED;
    end else if (cmd_i.eval && hit) begin
      if (is_lookup) begin
        res_allowed_r <= 1'b1;
      end else begin
        res_status_r <= widen ? STAT_WIDENED : STAT_UNCHANGED;
      end
    end else if (cmd_i.mark_full) begin
      res_status_r <= STAT_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_allowed_r <= res_allowed_r;
      out_status_r  <= res_status_r;
    end
  end

  assign out_allowed       = out_allowed_r;
  assign out_insert_status = out_status_r;

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_probe_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.eval |-> (mid < count_r && lo_r < hi_r))
    else $error("probe outside the valid entries");

  a_shift_above_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.sh_step |-> (wptr_r > lo_r && wptr_r <= count_r))
    else $error("shift pointer outside the moving span");

endmodule
